// ===== sv/mcmp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcmp_pkg
// types and constants shared by the midi channel message parser
// ----------------------------------------------------------------------------
package mcmp_pkg;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF       = 3'd0,
    KIND_NOTE_ON        = 3'd1,
    KIND_CONTROL_CHANGE = 3'd2,
    KIND_PITCH_BEND     = 3'd3,
    KIND_PROGRAM_CHANGE = 3'd4,
    KIND_AFTERTOUCH     = 3'd5
  } event_kind_t;

  localparam logic [3:0] NIB_NOTE_OFF       = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON        = 4'h9;
  localparam logic [3:0] NIB_POLY_TOUCH     = 4'hA;
  localparam logic [3:0] NIB_CONTROL_CHANGE = 4'hB;
  localparam logic [3:0] NIB_PROGRAM_CHANGE = 4'hC;
  localparam logic [3:0] NIB_CHANNEL_TOUCH  = 4'hD;
  localparam logic [3:0] NIB_PITCH_BEND     = 4'hE;
  localparam logic [3:0] NIB_SYSTEM         = 4'hF;

  localparam logic [4:0] RECEIVE_CHANNEL_RESET = 5'd1;

  typedef struct packed {
    event_kind_t kind;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
  } event_t;

  function automatic logic [1:0] length_of(input logic [3:0] nib);
    logic [1:0] len;
    case (nib)
      NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_TOUCH, NIB_CONTROL_CHANGE, NIB_PITCH_BEND:
        len = 2'd2;
      NIB_PROGRAM_CHANGE, NIB_CHANNEL_TOUCH:
        len = 2'd1;
      default:
        len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/midi_channel_message_parser.sv =====
// ----------------------------------------------------------------------------
// midi_channel_message_parser
// running status midi parser that emits channel voice events for one channel
//
//   channel  dir  handshake            payload
//   rx       in   rx_valid/rx_stall    rx_byte
//   event    out  event_valid/stall    event_kind, event_channel,
//                                      first_data, second_data
//   cfg      in   cfg_valid/cfg_ready  cfg_data (receive channel)
//
// one byte is parsed per cycle while rx_stall is low; the result word goes
// to the output register, or to the skid register behind it while one
// event waits, so a byte can still be taken; rx_stall rises only when both
// are full. state update and event decode are one pass of logic before the
// output register. rst is synchronous and returns receive channel to 1.
// ----------------------------------------------------------------------------
module midi_channel_message_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       event_valid,
  input  logic       event_stall,
  output logic [2:0] event_kind,
  output logic [3:0] event_channel,
  output logic [6:0] first_data,
  output logic [6:0] second_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  logic [4:0] receive_channel;
  logic [3:0] status_nibble;
  logic [3:0] message_channel;
  logic [1:0] expected_length;
  logic [1:0] received_count;
  logic [6:0] data_store [2];

  logic [3:0] status_nibble_next;
  logic [3:0] message_channel_next;
  logic [1:0] expected_length_next;
  logic [1:0] received_count_next;
  logic [6:0] data_store_next [2];

  mcmp_pkg::event_t out_word;
  mcmp_pkg::event_t skid_word;
  logic             skid_valid;

  logic             accept;
  logic             out_take;
  logic             is_status;
  logic             store_en;
  logic [1:0]       count_stored;
  logic             complete;
  logic             match;
  logic             res_valid;
  mcmp_pkg::event_t res_word;

  assign cfg_ready = 1'b1;
  assign rx_stall  = skid_valid;
  assign accept    = rx_valid && !rx_stall;
  assign out_take  = event_valid && !event_stall;

  always_comb begin
    status_nibble_next   = status_nibble;
    message_channel_next = message_channel;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    data_store_next      = data_store;
    res_valid            = 1'b0;
    res_word.kind        = mcmp_pkg::KIND_NOTE_OFF;
    res_word.channel     = message_channel;
    res_word.first_data  = data_store[0];
    res_word.second_data = 7'd0;

    is_status    = rx_byte[7];
    store_en     = received_count < expected_length;
    count_stored = store_en ? received_count + 2'd1 : received_count;
    complete     = count_stored == expected_length;
    match        = receive_channel == ({1'b0, message_channel} + 5'd1);

    if (is_status) begin
      if (rx_byte[7:4] != mcmp_pkg::NIB_SYSTEM) begin
        status_nibble_next   = rx_byte[7:4];
        message_channel_next = rx_byte[3:0];
        expected_length_next = mcmp_pkg::length_of(rx_byte[7:4]);
      end
    end else begin
      if (store_en) begin
        data_store_next[received_count[0]] = rx_byte[6:0];
      end
      received_count_next = complete ? 2'd0 : count_stored;
      res_word.first_data = data_store_next[0];
      if (complete && match) begin
        if (count_stored == 2'd2) begin
          res_word.second_data = data_store_next[1];
          case (status_nibble)
            mcmp_pkg::NIB_NOTE_OFF: begin
              res_valid     = 1'b1;
              res_word.kind = mcmp_pkg::KIND_NOTE_OFF;
            end
            mcmp_pkg::NIB_NOTE_ON: begin
              res_valid     = 1'b1;
              res_word.kind = mcmp_pkg::KIND_NOTE_ON;
            end
            mcmp_pkg::NIB_CONTROL_CHANGE: begin
              res_valid     = 1'b1;
              res_word.kind = mcmp_pkg::KIND_CONTROL_CHANGE;
            end
            mcmp_pkg::NIB_PITCH_BEND: begin
              res_valid     = 1'b1;
              res_word.kind = mcmp_pkg::KIND_PITCH_BEND;
            end
            default: res_valid = 1'b0;
          endcase
        end else if (count_stored == 2'd1) begin
          case (status_nibble)
            mcmp_pkg::NIB_PROGRAM_CHANGE: begin
              res_valid     = 1'b1;
              res_word.kind = mcmp_pkg::KIND_PROGRAM_CHANGE;
            end
            mcmp_pkg::NIB_CHANNEL_TOUCH: begin
              res_valid     = 1'b1;
              res_word.kind = mcmp_pkg::KIND_AFTERTOUCH;
            end
            default: res_valid = 1'b0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_channel <= mcmp_pkg::RECEIVE_CHANNEL_RESET;
      status_nibble   <= 4'd0;
      message_channel <= 4'd0;
      expected_length <= 2'd0;
      received_count  <= 2'd0;
      data_store[0]   <= 7'd0;
      data_store[1]   <= 7'd0;
      event_valid     <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        receive_channel <= cfg_data;
      end
      if (accept) begin
        status_nibble   <= status_nibble_next;
        message_channel <= message_channel_next;
        expected_length <= expected_length_next;
        received_count  <= received_count_next;
        data_store      <= data_store_next;
      end
      if (skid_valid) begin
        if (out_take) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end
      end else if (event_valid && !out_take) begin
        if (accept && res_valid) begin
          skid_word  <= res_word;
          skid_valid <= 1'b1;
        end
      end else begin
        event_valid <= accept && res_valid;
        if (accept && res_valid) begin
          out_word <= res_word;
        end
      end
    end
  end

  assign event_kind    = out_word.kind;
  assign event_channel = out_word.channel;
  assign first_data    = out_word.first_data;
  assign second_data   = out_word.second_data;

  // skid only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> event_valid)
    else $error("skid word without output word");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    received_count != 2'd3 && expected_length != 2'd3)
    else $error("data count out of range");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> event_kind <= 3'd5)
    else $error("event kind out of range");

  a_one_byte_zero: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == mcmp_pkg::KIND_PROGRAM_CHANGE ||
    event_kind == mcmp_pkg::KIND_AFTERTOUCH) |-> second_data == 7'd0)
    else $error("one byte message with nonzero second data");

  a_status_no_event: assert property (@(posedge clk) disable iff (rst)
    accept && rx_byte[7] && !event_valid |=> !event_valid)
    else $error("status byte produced an event");

endmodule

// ===== dv/mcmp_event_checker.sv =====
// ----------------------------------------------------------------------------
// mcmp_event_checker
// watches the byte, event and config channels of the midi parser, keeps its
// own running status decode of every accepted byte and compares each event
// word leaving the block, field by field, against the oldest predicted event
// ----------------------------------------------------------------------------
module mcmp_event_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        event_valid,
  input  logic        event_stall,
  input  logic [2:0]  event_kind,
  input  logic [3:0]  event_channel,
  input  logic [6:0]  first_data,
  input  logic [6:0]  second_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  logic [4:0]         listen_channel;
  logic [3:0]         cur_nib;
  logic [3:0]         cur_chan;
  logic [1:0]         want_len;
  logic [1:0]         got_count;
  logic [6:0]         held [2];
  mcmp_pkg::event_t   pending_events [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic decode_byte(input logic [7:0] b);
    mcmp_pkg::event_t ev;
    bit               hit;
    if (b[7]) begin
      if (b[7:4] != mcmp_pkg::NIB_SYSTEM) begin
        cur_nib  = b[7:4];
        cur_chan = b[3:0];
        case (b[7:4])
          mcmp_pkg::NIB_PROGRAM_CHANGE, mcmp_pkg::NIB_CHANNEL_TOUCH: want_len = 2'd1;
          default: want_len = 2'd2;
        endcase
      end
      return;
    end
    if (got_count < want_len) begin
      held[got_count[0]] = b[6:0];
      got_count = got_count + 2'd1;
    end
    if (got_count != want_len) return;
    hit            = 1'b0;
    ev.kind        = mcmp_pkg::KIND_NOTE_OFF;
    ev.channel     = cur_chan;
    ev.first_data  = held[0];
    ev.second_data = 7'd0;
    if (listen_channel >= 5'd1 && listen_channel <= 5'd16 &&
        (listen_channel - 5'd1) == {1'b0, cur_chan}) begin
      hit = 1'b1;
      if (got_count == 2'd2) begin
        ev.second_data = held[1];
        case (cur_nib)
          mcmp_pkg::NIB_NOTE_OFF:       ev.kind = mcmp_pkg::KIND_NOTE_OFF;
          mcmp_pkg::NIB_NOTE_ON:        ev.kind = mcmp_pkg::KIND_NOTE_ON;
          mcmp_pkg::NIB_CONTROL_CHANGE: ev.kind = mcmp_pkg::KIND_CONTROL_CHANGE;
          mcmp_pkg::NIB_PITCH_BEND:     ev.kind = mcmp_pkg::KIND_PITCH_BEND;
          default:                      hit = 1'b0;
        endcase
      end else if (got_count == 2'd1) begin
        case (cur_nib)
          mcmp_pkg::NIB_PROGRAM_CHANGE: ev.kind = mcmp_pkg::KIND_PROGRAM_CHANGE;
          mcmp_pkg::NIB_CHANNEL_TOUCH:  ev.kind = mcmp_pkg::KIND_AFTERTOUCH;
          default:                      hit = 1'b0;
        endcase
      end else begin
        hit = 1'b0;
      end
    end
    got_count = 2'd0;
    if (hit) pending_events.push_back(ev);
  endtask

  task automatic check_event();
    mcmp_pkg::event_t want;
    if (pending_events.size() == 0) begin
      $display("%0t: unexpected event word, expected none actual kind %0d ch %0d data %0d %0d",
               $time, event_kind, event_channel, first_data, second_data);
      mismatches++;
      return;
    end
    want = pending_events.pop_front();
    if (event_kind !== want.kind) begin
      $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, event_kind);
      mismatches++;
    end
    if (event_channel !== want.channel) begin
      $display("%0t: event_channel expected %0d actual %0d", $time, want.channel,
               event_channel);
      mismatches++;
    end
    if (first_data !== want.first_data) begin
      $display("%0t: first_data expected %0d actual %0d", $time, want.first_data, first_data);
      mismatches++;
    end
    if (second_data !== want.second_data) begin
      $display("%0t: second_data expected %0d actual %0d", $time, want.second_data,
               second_data);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      listen_channel = mcmp_pkg::RECEIVE_CHANNEL_RESET;
      cur_nib        = 4'd0;
      cur_chan       = 4'd0;
      want_len       = 2'd0;
      got_count      = 2'd0;
      held[0]        = 7'd0;
      held[1]        = 7'd0;
      pending_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) listen_channel = cfg_data;
      if (rx_valid && !rx_stall) decode_byte(rx_byte);
      if (event_valid && !event_stall) check_event();
    end
    outstanding <= pending_events.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives the midi parser with a short directed byte stream and then with
// random running status messages mixed with noise, broken messages and
// system bytes, over several receive channel settings, with random idle
// bursts on both channels; the checker beside the block scores the events
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       rx_valid    = 1'b0;
  logic [7:0] rx_byte     = 8'd0;
  logic       event_stall = 1'b0;
  logic       cfg_valid   = 1'b0;
  logic [4:0] cfg_data    = 5'd0;
  logic       rx_stall;
  logic       event_valid;
  logic [2:0] event_kind;
  logic [3:0] event_channel;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic       cfg_ready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned sent        = 0;
  int unsigned target;
  int          idle_mode   = 1;
  int          stall_left  = 0;
  logic [7:0]  last_status = 8'd0;
  logic [4:0]  listen_cfg  = mcmp_pkg::RECEIVE_CHANNEL_RESET;

  logic [7:0] opening_bytes [$] = '{
    8'h7F, 8'hF0,
    8'h90, 8'h3C, 8'h7F,
    8'h00, 8'h00,
    8'h80, 8'h7F, 8'h01,
    8'hB0, 8'h07, 8'h64,
    8'hE0, 8'h00, 8'h7F,
    8'hC0, 8'h05,
    8'hD0, 8'h7F,
    8'hA0, 8'h10, 8'h20,
    8'h9F, 8'h11, 8'hC0, 8'h22,
    8'hFF
  };

  always #5 clk = ~clk;

  midi_channel_message_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .event_valid   (event_valid),
    .event_stall   (event_stall),
    .event_kind    (event_kind),
    .event_channel (event_channel),
    .first_data    (first_data),
    .second_data   (second_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  mcmp_event_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .event_valid   (event_valid),
    .event_stall   (event_stall),
    .event_kind    (event_kind),
    .event_channel (event_channel),
    .first_data    (first_data),
    .second_data   (second_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || idle_mode == 0) begin
      event_stall <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      event_stall <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 99) < (idle_mode == 1 ? 6 : 15)) begin
      event_stall <= 1'b1;
      stall_left  <= $urandom_range(0, 17);
    end else begin
      event_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_mode != 0 && $urandom_range(0, 99) < (idle_mode == 1 ? 6 : 15)) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    if (b[7] && b[7:4] != mcmp_pkg::NIB_SYSTEM) last_status = b;
    if (b[7:4] != mcmp_pkg::NIB_SYSTEM) sent++;
  endtask

  task automatic send_message();
    logic [3:0] nib;
    logic [3:0] chan;
    logic [6:0] d;
    int         n;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    nib = mcmp_pkg::NIB_NOTE_OFF + 4'($urandom_range(0, 6));
    if (listen_cfg >= 5'd1 && listen_cfg <= 5'd16 && $urandom_range(0, 3) != 0)
      chan = 4'(listen_cfg - 5'd1);
    else
      chan = 4'($urandom_range(0, 15));
    n = (nib == mcmp_pkg::NIB_PROGRAM_CHANGE || nib == mcmp_pkg::NIB_CHANNEL_TOUCH) ? 1 : 2;
    // broken message: one data word short
    if (roll < 16) n = n - 1;
    if ({nib, chan} != last_status || $urandom_range(0, 2) == 0) send_byte({nib, chan});
    repeat (n) begin
      if ($urandom_range(0, 24) == 0) send_byte(8'($urandom_range(8'hF0, 8'hFF)));
      if ($urandom_range(0, 3) == 0) d = {7{$urandom_range(0, 1) == 1}};
      else d = 7'($urandom_range(0, 127));
      send_byte({1'b0, d});
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_receive_channel(input logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        rx_valid <= 1'b0;
        drain();
        case (p)
          1:       listen_cfg = 5'd16;
          2:       listen_cfg = 5'd0;
          3:       listen_cfg = 5'd1;
          4:       listen_cfg = 5'd31;
          5:       listen_cfg = 5'd17;
          6:       listen_cfg = 5'($urandom_range(2, 15));
          default: listen_cfg = 5'($urandom_range(1, 16));
        endcase
        write_receive_channel(listen_cfg);
      end
      idle_mode = (p == 7) ? 0 : p % 3;
      target    = sent + 65;
      while (sent < target) send_message();
    end
    rx_valid <= 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
